// ===== rtl/itp_pkg.sv =====
// Shared types, character codes and decode functions for the infix-to-postfix converter.
package itp_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CFG_W  = 6;

  // Characters the converter treats specially
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_POW    = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ADD    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SUB    = 8'h2D;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLS_OPERAND,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPERATOR
  } class_e;

  typedef enum logic [1:0] {
    SRC_CHAR,
    SRC_TOP,
    SRC_ZERO
  } src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CLOSE,
    S_OPLOOP,
    S_PUSH,
    S_SETTLE,
    S_END,
    S_FLUSH,
    S_FIN
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic    load_in;
    logic    emit;
    src_e    emit_src;
    status_e emit_stat;
    logic    pop;
    logic    push;
    logic    finish;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    class_e cls;
    logic   end_mark;
    logic   empty;
    logic   top_lparen;
    logic   pop_ok;
    logic   full;
    logic   can_emit;
    logic   can_finish;
    logic   pend_v;
  } sts_t;

  // Operator precedence, 0 for anything that is not an operator
  function automatic logic [1:0] prec_of(logic [CHAR_W-1:0] c);
    logic [1:0] p;
    unique case (c)
      CH_POW:         p = 2'd3;
      CH_MUL, CH_DIV: p = 2'd2;
      CH_ADD, CH_SUB: p = 2'd1;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic class_e class_of(logic [CHAR_W-1:0] c);
    class_e k;
    unique case (c)
      CH_LPAREN: k = CLS_LPAREN;
      CH_RPAREN: k = CLS_RPAREN;
      CH_POW, CH_MUL, CH_DIV, CH_ADD, CH_SUB: k = CLS_OPERATOR;
      default:   k = CLS_OPERAND;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/itp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/itp_dp.sv =====
// Datapath: input latch, operator stack, limit register, pending result and output register.
module itp_dp #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  itp_pkg::cmd_t               cmd_i,
  output itp_pkg::sts_t               sts_o,
  input  logic [itp_pkg::CHAR_W-1:0]  in_char_i,
  input  logic                        end_of_expr_i,
  input  logic                        cfg_we_i,
  input  logic [itp_pkg::CFG_W-1:0]   stack_limit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [itp_pkg::CHAR_W-1:0]  out_char_o,
  output logic                        last_of_run_o,
  output logic                        expr_done_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LW = (CW > itp_pkg::CFG_W) ? CW : itp_pkg::CFG_W;

  logic [itp_pkg::CHAR_W-1:0] char_q;
  logic                       end_q;
  logic [CW-1:0]              count_q, count_d, count_m1;
  logic [itp_pkg::CFG_W-1:0]  limit_q;
  logic [itp_pkg::CHAR_W-1:0] top;

  logic                       pend_v_q, pend_v_d;
  logic [itp_pkg::CHAR_W-1:0] pend_char_q, pend_char_d;
  itp_pkg::status_e           pend_stat_q, pend_stat_d;

  logic                       out_v_q, out_v_d;
  logic [itp_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic                       out_last_q, out_last_d;
  logic                       out_done_q, out_done_d;
  itp_pkg::status_e           out_stat_q, out_stat_d;

  logic [LW-1:0]              lim_ext, eff_lim;
  logic [1:0]                 p_in, p_top;
  logic                       out_free;
  logic [itp_pkg::CHAR_W-1:0] new_char;

  // Operator stack memory
  assign count_m1 = count_q - CW'(1);

  itp_ram #(
    .WIDTH (itp_pkg::CHAR_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (char_q),
    .raddr_i (count_m1[AW-1:0]),
    .rdata_o (top)
  );

  // Effective limit: zero acts as one, clipped to the stack depth
  always_comb begin
    lim_ext = LW'(limit_q);
    if (lim_ext == '0) begin
      eff_lim = LW'(1);
    end else if (lim_ext > LW'(STACK_DEPTH)) begin
      eff_lim = LW'(STACK_DEPTH);
    end else begin
      eff_lim = lim_ext;
    end
  end

  assign p_in     = itp_pkg::prec_of(char_q);
  assign p_top    = itp_pkg::prec_of(top);
  assign out_free = !out_v_q || !out_stall_i;

  // Status toward the controller
  always_comb begin
    sts_o.cls        = itp_pkg::class_of(char_q);
    sts_o.end_mark   = end_q;
    sts_o.empty      = (count_q == '0);
    sts_o.top_lparen = (top == itp_pkg::CH_LPAREN);
    sts_o.pop_ok     = (count_q != '0) && (p_top != 2'd0) &&
                       ((p_top > p_in) || ((p_top == p_in) && (char_q != itp_pkg::CH_POW)));
    sts_o.full       = (LW'(count_q) >= eff_lim);
    sts_o.can_emit   = !pend_v_q || out_free;
    sts_o.can_finish = out_free || (!pend_v_q && !end_q);
    sts_o.pend_v     = pend_v_q;
  end

  // Stack pointer
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_m1;
    end
  end

  // Result source select
  always_comb begin
    case (cmd_i.emit_src)
      itp_pkg::SRC_CHAR: new_char = char_q;
      itp_pkg::SRC_TOP:  new_char = top;
      default:           new_char = '0;
    endcase
  end

  // One-deep hold so the last result of a run can be marked, then the output register
  always_comb begin
    pend_v_d    = pend_v_q;
    pend_char_d = pend_char_q;
    pend_stat_d = pend_stat_q;
    out_v_d     = out_v_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_stat_d  = out_stat_q;
    if (cmd_i.emit) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_char_d = pend_char_q;
        out_stat_d = pend_stat_q;
        out_last_d = 1'b0;
        out_done_d = 1'b0;
      end
      pend_v_d    = 1'b1;
      pend_char_d = new_char;
      pend_stat_d = cmd_i.emit_stat;
    end else if (cmd_i.finish) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_char_d = pend_char_q;
        out_stat_d = pend_stat_q;
        out_last_d = 1'b1;
        out_done_d = end_q;
        pend_v_d   = 1'b0;
      end else if (end_q) begin
        // silent end: a marker beat so the end of the expression is seen
        out_v_d    = 1'b1;
        out_char_d = '0;
        out_stat_d = itp_pkg::ST_OK;
        out_last_d = 1'b1;
        out_done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      limit_q  <= itp_pkg::LIMIT_RESET;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        limit_q <= stack_limit_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      char_q <= in_char_i;
      end_q  <= end_of_expr_i;
    end
    pend_char_q <= pend_char_d;
    pend_stat_q <= pend_stat_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    out_stat_q  <= out_stat_d;
  end

  assign out_valid_o   = out_v_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;
  assign expr_done_o   = out_done_q;
  assign status_o      = out_stat_q;

endmodule

// ===== rtl/itp_ctrl.sv =====
// Controller: sequences one character through pops, push, flush and result marking.
module itp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  itp_pkg::sts_t sts_i,
  output itp_pkg::cmd_t cmd_o
);

  itp_pkg::state_e state_q, state_d;
  itp_pkg::state_e ret_q, ret_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itp_pkg::S_IDLE;
      ret_q   <= itp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    ret_d           = ret_q;
    in_stall_o      = 1'b1;
    cmd_o.load_in   = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_src  = itp_pkg::SRC_TOP;
    cmd_o.emit_stat = itp_pkg::ST_OK;
    cmd_o.pop       = 1'b0;
    cmd_o.push      = 1'b0;
    cmd_o.finish    = 1'b0;
    unique case (state_q)
      itp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = itp_pkg::S_EVAL;
        end
      end
      itp_pkg::S_EVAL: begin
        unique case (sts_i.cls)
          itp_pkg::CLS_LPAREN:   state_d = itp_pkg::S_PUSH;
          itp_pkg::CLS_RPAREN:   state_d = itp_pkg::S_CLOSE;
          itp_pkg::CLS_OPERATOR: state_d = itp_pkg::S_OPLOOP;
          default: begin
            if (sts_i.can_emit) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_src = itp_pkg::SRC_CHAR;
              state_d        = itp_pkg::S_END;
            end
          end
        endcase
      end
      itp_pkg::S_CLOSE: begin
        if (sts_i.empty) begin
          if (sts_i.can_emit) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_src  = itp_pkg::SRC_ZERO;
            cmd_o.emit_stat = itp_pkg::ST_UNMATCHED;
            state_d         = itp_pkg::S_END;
          end
        end else if (sts_i.top_lparen) begin
          cmd_o.pop = 1'b1;
          ret_d     = itp_pkg::S_END;
          state_d   = itp_pkg::S_SETTLE;
        end else if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.pop  = 1'b1;
          ret_d      = itp_pkg::S_CLOSE;
          state_d    = itp_pkg::S_SETTLE;
        end
      end
      itp_pkg::S_OPLOOP: begin
        if (sts_i.pop_ok) begin
          if (sts_i.can_emit) begin
            cmd_o.emit = 1'b1;
            cmd_o.pop  = 1'b1;
            ret_d      = itp_pkg::S_OPLOOP;
            state_d    = itp_pkg::S_SETTLE;
          end
        end else begin
          state_d = itp_pkg::S_PUSH;
        end
      end
      itp_pkg::S_PUSH: begin
        if (sts_i.full) begin
          if (sts_i.can_emit) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_src  = itp_pkg::SRC_ZERO;
            cmd_o.emit_stat = itp_pkg::ST_FULL;
            state_d         = itp_pkg::S_END;
          end
        end else begin
          cmd_o.push = 1'b1;
          ret_d      = itp_pkg::S_END;
          state_d    = itp_pkg::S_SETTLE;
        end
      end
      // stack read port catches up with the new top
      itp_pkg::S_SETTLE: state_d = ret_q;
      itp_pkg::S_END: begin
        state_d = sts_i.end_mark ? itp_pkg::S_FLUSH : itp_pkg::S_FIN;
      end
      itp_pkg::S_FLUSH: begin
        if (sts_i.empty) begin
          state_d = itp_pkg::S_FIN;
        end else if (sts_i.top_lparen) begin
          cmd_o.pop = 1'b1;
          ret_d     = itp_pkg::S_FLUSH;
          state_d   = itp_pkg::S_SETTLE;
        end else if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.pop  = 1'b1;
          ret_d      = itp_pkg::S_FLUSH;
          state_d    = itp_pkg::S_SETTLE;
        end
      end
      itp_pkg::S_FIN: begin
        if (sts_i.can_finish) begin
          cmd_o.finish = 1'b1;
          state_d      = itp_pkg::S_IDLE;
        end
      end
      default: state_d = itp_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
//
// Input channel: one ASCII character per beat (in_char_i) with end_of_expr_i
// on the last character of an expression. Output channel: postfix characters,
// with last_of_run_o on the last beat a character causes, expr_done_o on the
// final beat of an expression, and status_o flagging a dropped push (stack
// full) or an unmatched ')' on a marker beat whose character is zero.
// Configuration: stack_limit_i must be written on a cfg_valid_i beat only
// while idle; the block itself does not enforce this. cfg_ready_o is always
// high. Reset clears the stack and sets the limit to 32. After accept, each
// stack pop or push passes through a settle state while the pointer moves and
// the registered read of the new top of the memory catches up; an operator
// ends with a final precedence check, a dropped push or an unmatched ')' emits
// a marker, and an end mark flushes the stack entry by entry. A character's
// results pass through a one-deep hold so the last can be marked; with several
// results the first leaves as the second is produced. One character is in work
// at a time; in_stall_o is high from accept until its last result sits in the
// output register. A stall at the output holds that register and one pending
// result, then stops the sequence.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [itp_pkg::CHAR_W-1:0] in_char_i,
  input  logic                       end_of_expr_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [itp_pkg::CHAR_W-1:0] out_char_o,
  output logic                       last_of_run_o,
  output logic                       expr_done_o,
  output logic [1:0]                 status_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [itp_pkg::CFG_W-1:0]  stack_limit_i
);

  itp_pkg::cmd_t cmd;
  itp_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_char_i     (in_char_i),
    .end_of_expr_i (end_of_expr_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .stack_limit_i (stack_limit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o),
    .expr_done_o   (expr_done_o),
    .status_o      (status_o)
  );

  // A new character never starts while a result of the previous one is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !sts.pend_v)
    else $error("input accepted with a pending result");

  // The controller never pushes onto a full stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.full)
    else $error("push issued on a full stack");

  // End of expression is always the last beat of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && expr_done_o) |-> last_of_run_o)
    else $error("expr_done without last_of_run");

  // Error flags only ride on marker beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != itp_pkg::ST_OK)) |-> (out_char_o == '0))
    else $error("nonzero status on a character beat");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the infix-to-postfix converter: directed and random character streams.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STACK_DEPTH    = 32;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned PHASE_CHARS    = 10;

  // One expected or observed output beat
  typedef struct packed {
    logic [itp_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       done;
    logic [1:0]                 st;
  } postfix_beat_t;

  // Shunting-yard predictor plus the queue of postfix beats still owed
  class postfix_scoreboard;
    logic [itp_pkg::CHAR_W-1:0] op_stack [STACK_DEPTH];
    int unsigned                depth_used;
    logic [itp_pkg::CFG_W-1:0]  stack_limit;
    postfix_beat_t              run_q[$];
    postfix_beat_t              expected_q[$];
    int                         errors;

    function new();
      depth_used  = 0;
      stack_limit = itp_pkg::LIMIT_RESET;
      errors      = 0;
    endfunction

    function void set_limit(logic [itp_pkg::CFG_W-1:0] v);
      stack_limit = v;
    endfunction

    function logic [1:0] op_rank(logic [itp_pkg::CHAR_W-1:0] c);
      if (c == itp_pkg::CH_POW) return 2'd3;
      if (c == itp_pkg::CH_MUL || c == itp_pkg::CH_DIV) return 2'd2;
      if (c == itp_pkg::CH_ADD || c == itp_pkg::CH_SUB) return 2'd1;
      return 2'd0;
    endfunction

    // 0 behaves as 1, anything past the physical depth is clamped
    function int unsigned usable_depth();
      int unsigned lim;
      lim = 32'(stack_limit);
      if (lim < 1) lim = 1;
      if (lim > STACK_DEPTH) lim = STACK_DEPTH;
      return lim;
    endfunction

    function void put_beat(logic [itp_pkg::CHAR_W-1:0] ch, logic [1:0] st);
      postfix_beat_t b;
      b.ch   = ch;
      b.last = 1'b0;
      b.done = 1'b0;
      b.st   = st;
      run_q.push_back(b);
    endfunction

    function logic [itp_pkg::CHAR_W-1:0] pop_op();
      if (depth_used == 0) return '0;
      depth_used--;
      return op_stack[depth_used];
    endfunction

    // A push against a full stack is dropped and flagged in the stream
    function void push_op(logic [itp_pkg::CHAR_W-1:0] c);
      if (depth_used >= usable_depth()) begin
        put_beat('0, itp_pkg::ST_FULL);
      end else begin
        op_stack[depth_used] = c;
        depth_used++;
      end
    endfunction

    function void note_char(logic [itp_pkg::CHAR_W-1:0] c, logic eoe);
      logic [itp_pkg::CHAR_W-1:0] t;
      logic [1:0]                 p;
      logic [1:0]                 tp;
      bit                         matched;
      run_q.delete();
      p = op_rank(c);
      if (c == itp_pkg::CH_LPAREN) begin
        push_op(c);
      end else if (c == itp_pkg::CH_RPAREN) begin
        matched = 1'b0;
        while (depth_used > 0) begin
          t = pop_op();
          if (t == itp_pkg::CH_LPAREN) begin
            matched = 1'b1;
            break;
          end
          put_beat(t, itp_pkg::ST_OK);
        end
        if (!matched) put_beat('0, itp_pkg::ST_UNMATCHED);
      end else if (p != 0) begin
        // pop stronger operators, equal ones too unless right-associative
        while (depth_used > 0) begin
          t  = op_stack[depth_used-1];
          tp = op_rank(t);
          if (tp == 0) break;
          if (tp > p || (tp == p && c != itp_pkg::CH_POW)) put_beat(pop_op(), itp_pkg::ST_OK);
          else break;
        end
        push_op(c);
      end else begin
        put_beat(c, itp_pkg::ST_OK);
      end
      // end mark flushes; stray open parens vanish
      if (eoe) begin
        while (depth_used > 0) begin
          t = pop_op();
          if (t != itp_pkg::CH_LPAREN) put_beat(t, itp_pkg::ST_OK);
        end
        if (run_q.size() == 0) put_beat('0, itp_pkg::ST_OK);
      end
      if (run_q.size() > 0) begin
        run_q[run_q.size()-1].last = 1'b1;
        if (eoe) run_q[run_q.size()-1].done = 1'b1;
      end
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_beat(postfix_beat_t got);
      postfix_beat_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected beat, expected none, actual char %0h", $time, got.ch);
        return;
      end
      want = expected_q.pop_front();
      if (want.ch !== got.ch) report("out_char", 32'(want.ch), 32'(got.ch));
      if (want.last !== got.last) report("last_of_run", 32'(want.last), 32'(got.last));
      if (want.done !== got.done) report("expr_done", 32'(want.done), 32'(got.done));
      if (want.st !== got.st) report("status", 32'(want.st), 32'(got.st));
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [itp_pkg::CHAR_W-1:0] in_char_i = '0;
  logic                       end_of_expr_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [itp_pkg::CHAR_W-1:0] out_char_o;
  logic                       last_of_run_o;
  logic                       expr_done_o;
  logic [1:0]                 status_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [itp_pkg::CFG_W-1:0]  stack_limit_i = itp_pkg::LIMIT_RESET;

  postfix_scoreboard sb;
  bit                idle_en = 1'b1;
  bit                hold_go = 1'b0;
  int unsigned       chars_sent = 0;
  int unsigned       quiet_cycles = 0;

  // Handshake state sampled mid-cycle, where nothing moves
  bit                         in_fire_n, out_fire_n, cfg_fire_n;
  logic [itp_pkg::CHAR_W-1:0] in_char_n;
  logic                       end_n;
  postfix_beat_t              out_beat_n;
  logic [itp_pkg::CFG_W-1:0]  cfg_data_n;

  infix_to_postfix_converter #(
    .STACK_DEPTH (STACK_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_char_i     (in_char_i),
    .end_of_expr_i (end_of_expr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o),
    .expr_done_o   (expr_done_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .stack_limit_i (stack_limit_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    in_fire_n  = rst_ni && (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
    out_fire_n = rst_ni && (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
    cfg_fire_n = rst_ni && (cfg_valid_i === 1'b1) && (cfg_ready_o === 1'b1);
    in_char_n  = in_char_i;
    end_n      = end_of_expr_i;
    out_beat_n = '{ch: out_char_o, last: last_of_run_o, done: expr_done_o, st: status_o};
    cfg_data_n = stack_limit_i;
  end

  // Beat monitor, scoreboard updates and watchdog
  always @(posedge clk_i) begin
    if (in_fire_n) sb.note_char(in_char_n, end_n);
    if (out_fire_n) sb.check_beat(out_beat_n);
    if (cfg_fire_n) sb.set_limit(cfg_data_n);
    if (in_fire_n || out_fire_n || cfg_fire_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= idle_en && ($urandom_range(99) < 9);
      end
      @(posedge clk_i);
    end
  end

  task automatic send_char(input logic [itp_pkg::CHAR_W-1:0] c, input logic eoe);
    if (idle_en && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_char_i     <= c;
    end_of_expr_i <= eoe;
    @(posedge clk_i);
    while (!in_fire_n) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_seq(input string s, input bit mark_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], mark_end && (i == s.len() - 1));
  endtask

  // Let every owed beat arrive, then give a push-only character time to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [itp_pkg::CFG_W-1:0] v);
    cfg_valid_i   <= 1'b1;
    stack_limit_i <= v;
    @(posedge clk_i);
    while (!cfg_fire_n) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic bit is_special(logic [itp_pkg::CHAR_W-1:0] c);
    return c == itp_pkg::CH_LPAREN || c == itp_pkg::CH_RPAREN || c == itp_pkg::CH_POW ||
           c == itp_pkg::CH_MUL || c == itp_pkg::CH_DIV || c == itp_pkg::CH_ADD ||
           c == itp_pkg::CH_SUB;
  endfunction

  function automatic logic [itp_pkg::CHAR_W-1:0] pick_op();
    case ($urandom_range(4))
      0:       return itp_pkg::CH_POW;
      1:       return itp_pkg::CH_MUL;
      2:       return itp_pkg::CH_DIV;
      3:       return itp_pkg::CH_ADD;
      default: return itp_pkg::CH_SUB;
    endcase
  endfunction

  function automatic logic [itp_pkg::CHAR_W-1:0] pick_special();
    case ($urandom_range(6))
      0:       return itp_pkg::CH_LPAREN;
      1:       return itp_pkg::CH_RPAREN;
      default: return pick_op();
    endcase
  endfunction

  // Mostly letters, sometimes any non-special byte
  function automatic logic [itp_pkg::CHAR_W-1:0] pick_operand();
    logic [itp_pkg::CHAR_W-1:0] c;
    if ($urandom_range(9) < 7) return 8'h61 + itp_pkg::CHAR_W'($urandom_range(25));
    c = itp_pkg::CHAR_W'($urandom_range(255));
    while (is_special(c)) c = itp_pkg::CHAR_W'($urandom_range(255));
    return c;
  endfunction

  // Well-formed expression with random nesting, rarely left with open parens
  task automatic send_expr();
    logic [itp_pkg::CHAR_W-1:0] toks[$];
    int                         depth;
    int                         nterms;
    depth  = 0;
    nterms = $urandom_range(1, 8);
    for (int i = 0; i < nterms; i++) begin
      if (i > 0) toks.push_back(pick_op());
      while (depth < 6 && $urandom_range(99) < 25) begin
        toks.push_back(itp_pkg::CH_LPAREN);
        depth++;
      end
      toks.push_back(pick_operand());
      while (depth > 0 && $urandom_range(99) < 30) begin
        toks.push_back(itp_pkg::CH_RPAREN);
        depth--;
      end
    end
    if ($urandom_range(9) != 0)
      while (depth > 0) begin
        toks.push_back(itp_pkg::CH_RPAREN);
        depth--;
      end
    foreach (toks[i]) send_char(toks[i], i == toks.size() - 1);
  endtask

  // Right-associative chain: every '^' stacks, so the flush runs deep
  task automatic send_pow_chain();
    int n;
    n = $urandom_range(4, 34);
    for (int i = 0; i < n; i++) begin
      send_char(pick_operand(), 1'b0);
      send_char(itp_pkg::CH_POW, 1'b0);
    end
    send_char(pick_operand(), 1'b1);
  endtask

  // Broken input: specials at random, end marks at random
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      send_char($urandom_range(1) ? pick_special() : itp_pkg::CHAR_W'($urandom_range(255)),
                $urandom_range(7) == 0);
  endtask

  initial begin
    logic [itp_pkg::CFG_W-1:0] phase_limit [7];
    int                        r;
    int unsigned               goal;
    sb = new();
    phase_limit = '{6'd5, 6'd0, 6'd32, 6'd63, 6'd2, 6'd1, 6'd17};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme codes, every operator, associativity
    send_char(8'h00, 1'b0);
    send_char(itp_pkg::CH_ADD, 1'b0);
    send_char(8'hFF, 1'b0);
    send_seq("*b^c^d-e/f", 1'b1);
    // parens, unmatched close, lone open paren at the end mark
    send_seq("(a-b)*c", 1'b1);
    send_seq("a)", 1'b1);
    send_seq("(", 1'b1);
    // full stack at the smallest limit
    settle();
    write_limit(6'd1);
    send_seq("a+b*c", 1'b1);
    // limit lowered under a populated stack
    settle();
    write_limit(6'd32);
    send_seq("(((", 1'b0);
    settle();
    write_limit(6'd1);
    send_seq("+)", 1'b1);

    // Random phases, one limit each
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      write_limit(phase_limit[ph]);
      idle_en = (ph != 1);
      goal = chars_sent + PHASE_CHARS;
      // long receiver hold-off while characters keep coming
      if (ph == 2) hold_go = 1'b1;
      while (chars_sent < goal) begin
        r = $urandom_range(99);
        if (r < 12) send_noise();
        else if (r < 22) send_pow_chain();
        else send_expr();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
